[hdl/image_pyramid_box_downsampler_defines.svh]
// ----------------------------------------------------------------------------
// image pyramid box downsampler assertion macros
// shared concurrent checks, clocked on the rising edge, reset active low
// ----------------------------------------------------------------------------
`ifndef IMAGE_PYRAMID_BOX_DOWNSAMPLER_DEFINES_SVH
`define IMAGE_PYRAMID_BOX_DOWNSAMPLER_DEFINES_SVH

// same-cycle implication
`define IPBD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ipbd: same-cycle check failed");

// next-cycle implication
`define IPBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ipbd: next-cycle check failed");

`endif

[hdl/ipbd_pkg.sv]
// ----------------------------------------------------------------------------
// ipbd_pkg
// shared types, constants and helpers of the pyramid box downsampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipbd_pkg;

    localparam int DEFAULT_MAX_WIDTH   = 4096;
    localparam int DEFAULT_MAX_HEIGHT  = 4096;
    localparam int DEFAULT_MAX_LEVELS  = 12;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int DIM_W     = 13;
    localparam int LOG_W     = $clog2(DIM_W);
    localparam int POS_W     = 12;
    localparam int LEVEL_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int RESET_DIM = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_STEP  = 3'b010,
        ST_FETCH = 3'b100
    } eng_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(2)) begin
            r = DIM_W'(2);
        end else if (32'(v) > maxv) begin
            r = DIM_W'(maxv);
        end
        return r;
    endfunction

    function automatic logic [LOG_W-1:0] floor_log2(input logic [DIM_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 1; i < DIM_W; i++) begin
            if (v[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

[hdl/ipbd_ram.sv]
// ----------------------------------------------------------------------------
// ipbd_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipbd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/image_pyramid_box_downsampler.sv]
// ----------------------------------------------------------------------------
// image_pyramid_box_downsampler
// streaming 2x2 box pyramid: passes base pixels through as level 0 and
// emits every coarser pixel as soon as its block is complete
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_sample
//   m_       out        m_valid / m_ready    m_level m_pos_x m_pos_y m_value m_last
//   cfg_     in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// each level-0 beat is one engine step; each coarser level it completes adds a
// row store read, then a sum, before its own step
// one input beat is held while the engine works, so input overlaps output
// aresetn is synchronous, active low; clears counters, not the row store
// m_ready low stalls the engine while a result is pending; a config write restarts the image
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "image_pyramid_box_downsampler_defines.svh"

module image_pyramid_box_downsampler import ipbd_pkg::*; #(
    parameter int MAX_WIDTH   = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEFAULT_MAX_HEIGHT,
    parameter int MAX_LEVELS  = DEFAULT_MAX_LEVELS,
    parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEVEL_W-1:0]     m_level,
    output logic [POS_W-1:0]       m_pos_x,
    output logic [POS_W-1:0]       m_pos_y,
    output logic [SAMPLE_BITS-1:0] m_value,
    output logic                   m_last
);

    localparam int X_W    = ($clog2(MAX_WIDTH) < DIM_W) ? $clog2(MAX_WIDTH) : DIM_W;
    localparam int Y_W    = ($clog2(MAX_HEIGHT) < DIM_W) ? $clog2(MAX_HEIGHT) : DIM_W;
    localparam int LVL_W  = $clog2(MAX_LEVELS);
    localparam int NL_W   = LVL_W + 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int IDX_W  = DIM_W + 1;
    localparam int HOLD_W = SAMPLE_BITS + 1;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    // configuration
    logic             cfg_fire;
    logic [DIM_W-1:0] cfg_w_clamp;
    logic [DIM_W-1:0] cfg_h_clamp;
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic             scale_reg;
    logic [LOG_W-1:0] lw_reg;
    logic [LOG_W-1:0] lh_reg;
    logic [LOG_W-1:0] lmin;
    logic [NL_W-1:0]  nlev;

    // per-level state
    logic [X_W-1:0]    col_reg  [MAX_LEVELS];
    logic [Y_W-1:0]    row_reg  [MAX_LEVELS];
    logic [HOLD_W-1:0] hold_reg [MAX_LEVELS];

    // input holding stage and engine
    logic                   buf_valid_reg;
    logic [SAMPLE_BITS-1:0] buf_sample_reg;
    eng_state_t             st_reg;
    eng_state_t             st_next;
    logic [LVL_W-1:0]       lvl_reg;
    logic [SAMPLE_BITS-1:0] val_reg;
    logic [IDX_W-1:0]       off_reg;
    logic [HOLD_W-1:0]      psum_reg;

    // output register
    logic                   m_valid_reg;
    logic [LEVEL_W-1:0]     m_level_reg;
    logic [POS_W-1:0]       m_pos_x_reg;
    logic [POS_W-1:0]       m_pos_y_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;
    logic                   m_last_reg;

    // step datapath
    logic                   out_free;
    logic                   src_new;
    logic                   do_step;
    logic                   take;
    logic                   s_fire;
    logic [LVL_W-1:0]       k;
    logic [NL_W-1:0]        k1;
    logic [SAMPLE_BITS-1:0] v;
    logic [IDX_W-1:0]       off;
    logic [X_W-1:0]         x;
    logic [Y_W-1:0]         y;
    logic [DIM_W-1:0]       wk;
    logic [DIM_W-1:0]       hk;
    logic [DIM_W-1:0]       wn;
    logic [DIM_W-1:0]       hn;
    logic [DIM_W:0]         x_inc;
    logic [DIM_W:0]         y_inc;
    logic                   x_wrap;
    logic                   y_wrap;
    logic                   deeper;
    logic [HOLD_W-1:0]      pair;
    logic [IDX_W-1:0]       idx;
    logic                   idx_ok;
    logic                   hold_wr;
    logic                   ram_we;
    logic                   ram_re;
    logic                   step_last;
    logic [SUM_W-1:0]       ram_rdata;
    logic [SUM_W-1:0]       blk_sum;
    logic [SAMPLE_BITS-1:0] v_new;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign cfg_w_clamp = clamp_dim(cfg_data, MAX_WIDTH);
    assign cfg_h_clamp = clamp_dim(cfg_data, MAX_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg     <= clamp_dim(DIM_W'(RESET_DIM), MAX_WIDTH);
            h_reg     <= clamp_dim(DIM_W'(RESET_DIM), MAX_HEIGHT);
            lw_reg    <= floor_log2(clamp_dim(DIM_W'(RESET_DIM), MAX_WIDTH));
            lh_reg    <= floor_log2(clamp_dim(DIM_W'(RESET_DIM), MAX_HEIGHT));
            scale_reg <= 1'b0;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    w_reg  <= cfg_w_clamp;
                    lw_reg <= floor_log2(cfg_w_clamp);
                end
                REG_IMAGE_HEIGHT: begin
                    h_reg  <= cfg_h_clamp;
                    lh_reg <= floor_log2(cfg_h_clamp);
                end
                REG_SCALE_MODE: begin
                    scale_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        lmin = (lw_reg < lh_reg) ? lw_reg : lh_reg;
        if (32'(lmin) > MAX_LEVELS) begin
            nlev = NL_W'(MAX_LEVELS);
        end else if (lmin == '0) begin
            nlev = NL_W'(1);
        end else begin
            nlev = NL_W'(lmin);
        end
    end

    // engine step: one level of one pixel
    assign out_free = !m_valid_reg || m_ready;
    assign src_new  = (st_reg == ST_IDLE) && buf_valid_reg;
    assign do_step  = out_free && (src_new || (st_reg == ST_STEP));
    assign take     = do_step && src_new;
    assign s_ready  = !buf_valid_reg || take;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        k         = src_new ? '0 : lvl_reg;
        v         = src_new ? buf_sample_reg : val_reg;
        off       = src_new ? '0 : off_reg;
        k1        = NL_W'(k) + NL_W'(1);
        x         = col_reg[k];
        y         = row_reg[k];
        wk        = w_reg >> k;
        hk        = h_reg >> k;
        wn        = w_reg >> k1;
        hn        = h_reg >> k1;
        x_inc     = (DIM_W+1)'(x) + (DIM_W+1)'(1);
        y_inc     = (DIM_W+1)'(y) + (DIM_W+1)'(1);
        x_wrap    = x_inc >= (DIM_W+1)'(wk);
        y_wrap    = y_inc >= (DIM_W+1)'(hk);
        deeper    = (k1 < nlev) && (DIM_W'(x >> 1) < wn) && (DIM_W'(y >> 1) < hn);
        pair      = hold_reg[k] + HOLD_W'(v);
        idx       = off + IDX_W'(x >> 1);
        idx_ok    = 32'(idx) < MAX_WIDTH;
        hold_wr   = do_step && deeper && !x[0];
        ram_we    = do_step && deeper && x[0] && idx_ok && !y[0];
        ram_re    = do_step && deeper && x[0] && idx_ok && y[0];
        step_last = !ram_re;
    end

    // block sum once the row store answers
    assign blk_sum = ram_rdata + SUM_W'(psum_reg);
    assign v_new   = scale_reg ? SAMPLE_BITS'(blk_sum >> 3) : SAMPLE_BITS'(blk_sum >> 2);

    ipbd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx[ADDR_W-1:0]),
        .wdata (SUM_W'(pair)),
        .re    (ram_re),
        .raddr (idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // per-level counters and pending pair sums
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (!aresetn || cfg_fire) begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                hold_reg[i] <= '0;
            end else if (do_step && (k == LVL_W'(i))) begin
                if (x_wrap) begin
                    col_reg[i] <= '0;
                    row_reg[i] <= y_wrap ? '0 : Y_W'(y_inc);
                end else begin
                    col_reg[i] <= X_W'(x_inc);
                end
                if (hold_wr) begin
                    hold_reg[i] <= HOLD_W'(v);
                end
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (ram_re) begin
                    st_next = ST_FETCH;
                end
            end
            ST_STEP: begin
                if (do_step) begin
                    st_next = ram_re ? ST_FETCH : ST_IDLE;
                end
            end
            ST_FETCH: begin
                st_next = ST_STEP;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            lvl_reg  <= LVL_W'(k1);
            off_reg  <= off + IDX_W'(wn);
            psum_reg <= pair;
        end
        if (st_reg == ST_FETCH) begin
            val_reg <= v_new;
        end
    end

    // input holding stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
        end else if (s_fire) begin
            buf_valid_reg <= 1'b1;
        end else if (take) begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            buf_sample_reg <= s_sample;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            m_level_reg <= LEVEL_W'(k);
            m_pos_x_reg <= POS_W'(x);
            m_pos_y_reg <= POS_W'(y);
            m_value_reg <= v;
            m_last_reg  <= step_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_pos_x = m_pos_x_reg;
    assign m_pos_y = m_pos_y_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    `IPBD_ASSERT_NOW(a_store_rw_excl, aclk, aresetn, ram_re, !ram_we)
    `IPBD_ASSERT_NEXT(a_read_to_fetch, aclk, aresetn, ram_re, st_reg == ST_FETCH)
    `IPBD_ASSERT_NEXT(a_fetch_to_step, aclk, aresetn, st_reg == ST_FETCH, st_reg == ST_STEP)
    `IPBD_ASSERT_NOW(a_cascade_reads, aclk, aresetn, do_step && !step_last, ram_re)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for image_pyramid_box_downsampler
// streams base pixels into the 2x2 box pyramid under random handshake gaps.
// an untimed predictor works out every level pixel that each accepted beat
// completes, and the monitor compares result beats in order, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ipbd_pkg::*;

    localparam int SAMPLE_W      = DEFAULT_SAMPLE_BITS;
    localparam int NUM_LEVELS    = DEFAULT_MAX_LEVELS;
    localparam int STORE_DEPTH   = DEFAULT_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } pyr_pixel_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_sample  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [LEVEL_W-1:0]     m_level;
    logic [POS_W-1:0]       m_pos_x;
    logic [POS_W-1:0]       m_pos_y;
    logic [SAMPLE_W-1:0]    m_value;
    logic                   m_last;

    logic [SAMPLE_W-1:0] sample_q [$];
    pyr_pixel_t          pyramid_q [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold_off    = 1'b0;
    logic        pressure_go    = 1'b0;
    int unsigned mismatches     = 0;

    // predictor copy of registers and pyramid state
    logic [DIM_W-1:0]    img_width;
    logic [DIM_W-1:0]    img_height;
    logic                img_scale;
    logic [POS_W-1:0]    col_cnt  [NUM_LEVELS];
    logic [POS_W-1:0]    row_cnt  [NUM_LEVELS];
    logic [SAMPLE_W:0]   pair_sum [NUM_LEVELS];
    logic [SAMPLE_W+1:0] row_sums [STORE_DEPTH];

    image_pyramid_box_downsampler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_level   (m_level),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_value   (m_value),
        .m_last    (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic void restart_image();
        for (int i = 0; i < NUM_LEVELS; i++) begin
            col_cnt[i]  = '0;
            row_cnt[i]  = '0;
            pair_sum[i] = '0;
        end
    endfunction

    function automatic int unsigned dim_in_range(input logic [DIM_W-1:0] v,
                                                 input int unsigned limit);
        int unsigned d;
        d = v;
        if (d < 2) begin
            d = 2;
        end
        if (d > limit) begin
            d = limit;
        end
        return d;
    endfunction

    // every pixel that one base beat completes, bottom level first
    function automatic void predict_pyramid(input logic [SAMPLE_W-1:0] sample);
        int unsigned         w, h, nlev, lvl, x, y, off, idx, lw, lh;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W:0]   pair;
        logic [SAMPLE_W+1:0] blk;
        pyr_pixel_t          px;
        bit                  done;
        w    = dim_in_range(img_width, DEFAULT_MAX_WIDTH);
        h    = dim_in_range(img_height, DEFAULT_MAX_HEIGHT);
        lw   = $clog2(w + 1) - 1;
        lh   = $clog2(h + 1) - 1;
        nlev = (lw < lh) ? lw : lh;
        if (nlev > NUM_LEVELS) begin
            nlev = NUM_LEVELS;
        end
        if (nlev < 1) begin
            nlev = 1;
        end
        v    = sample;
        lvl  = 0;
        done = 1'b0;
        while (!done) begin
            x = col_cnt[lvl];
            y = row_cnt[lvl];
            px.level = LEVEL_W'(lvl);
            px.pos_x = POS_W'(x);
            px.pos_y = POS_W'(y);
            px.value = v;
            if (x + 1 >= (w >> lvl)) begin
                col_cnt[lvl] = '0;
                row_cnt[lvl] = (y + 1 >= (h >> lvl)) ? '0 : POS_W'(y + 1);
            end else begin
                col_cnt[lvl] = POS_W'(x + 1);
            end
            // the top level, or an odd trailing column or row, feeds nothing coarser
            if (lvl + 1 >= nlev || (x >> 1) >= (w >> (lvl + 1))
                    || (y >> 1) >= (h >> (lvl + 1))) begin
                done = 1'b1;
            end else if ((x & 1) == 0) begin
                pair_sum[lvl] = v;
                done = 1'b1;
            end else begin
                pair = pair_sum[lvl] + v;
                off  = 0;
                for (int j = 1; j <= lvl; j++) begin
                    off += w >> j;
                end
                idx = off + (x >> 1);
                if (idx >= STORE_DEPTH) begin
                    done = 1'b1;
                end else if ((y & 1) == 0) begin
                    row_sums[idx] = pair;
                    done = 1'b1;
                end else begin
                    blk = row_sums[idx] + pair;
                    v   = img_scale ? blk[SAMPLE_W+1:3] : blk[SAMPLE_W+1:2];
                    lvl++;
                end
            end
            px.last = done;
            pyramid_q.push_back(px);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_pyramid(s_sample);
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        pyr_pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pyramid_q.size() == 0) begin
                    $error("level %0d beat at (%0d,%0d) with nothing expected",
                           m_level, m_pos_x, m_pos_y);
                    mismatches++;
                end else begin
                    want = pyramid_q.pop_front();
                    check_field("level", want.level, m_level);
                    check_field("pos_x", want.pos_x, m_pos_x);
                    check_field("pos_y", want.pos_y, m_pos_y);
                    check_field("value", want.value, m_value);
                    check_field("last", want.last, m_last);
                end
            end
            m_ready <= !rx_hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        rx_hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold_off <= 1'b0;
    end

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (sample_q.size() != 0 || s_valid || pyramid_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  img_width  = data;
            REG_IMAGE_HEIGHT: img_height = data;
            REG_SCALE_MODE:   img_scale  = data[0];
            default: ;
        endcase
        restart_image();
        @(negedge aclk);
    endtask

    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic [DIM_W-1:0] mode);
        wait_drained();
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, DIM_W'($urandom));
        end
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SCALE_MODE, mode);
    endtask

    task automatic push_samples(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
                0:       sample_q.push_back('0);
                1:       sample_q.push_back('1);
                default: sample_q.push_back(SAMPLE_W'($urandom));
            endcase
        end
    endtask

    initial begin
        int unsigned w, h, n, queued;
        img_width  = DIM_W'(RESET_DIM);
        img_height = DIM_W'(RESET_DIM);
        img_scale  = 1'b0;
        restart_image();
        foreach (row_sums[i]) begin
            row_sums[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset sizes, start of the first row only
        sample_q.push_back('1);
        sample_q.push_back('0);
        sample_q.push_back('1);
        wait_drained();
        // restart mid-image through an unmapped index
        write_reg(REG_UNUSED, '1);
        // sizes below range clamp to 2 x 2, one beat past the end wraps
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        write_reg(REG_SCALE_MODE, 13'd0);
        sample_q.push_back('1);
        sample_q.push_back('0);
        sample_q.push_back('1);
        sample_q.push_back(16'h0001);
        sample_q.push_back(16'h8000);
        // full-scale 4 x 4 with per-level halving
        configure(13'd4, 13'd4, 13'h1fff);
        repeat (16) sample_q.push_back('1);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            queued = 0;
            while (queued < 50) begin
                if ($urandom_range(7) == 0) begin
                    // wide or oversized image, only part of its first row
                    configure(DIM_W'($urandom_range(1024, 8191)), DIM_W'($urandom),
                              DIM_W'($urandom));
                    n = $urandom_range(6, 24);
                end else begin
                    w = $urandom_range(2, 13);
                    h = $urandom_range(2, 13);
                    configure(DIM_W'(w), DIM_W'(h), DIM_W'($urandom));
                    n = w * h * $urandom_range(1, 2);
                    if ($urandom_range(4) == 0) begin
                        n = $urandom_range(1, w * h - 1);
                    end
                end
                push_samples(n);
                queued += n;
            end
        end

        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(13'd16, 13'd16, DIM_W'($urandom));
        pressure_go = 1'b1;
        push_samples(128);

        wait_drained();
        repeat (64) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
